@@ rtl/adac_pkg.sv @@
`default_nettype none

package adac_pkg;

  typedef enum logic [1:0] {
    OP_HDR = 2'd0,
    OP_DIM = 2'd1,
    OP_IDX = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_DIM,
    CMD_IDX
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_ADDR
  } back_state_t;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  id;
    logic [3:0]  pos;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [31:0] address;
    logic [3:0]  id;
    logic        count_ok;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/adac_fifo.sv @@
`default_nettype none

module adac_fifo
  import adac_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  logic [WIDTH-1:0]  mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/adac_front.sv @@
`default_nettype none

module adac_front
  import adac_pkg::*;
#(
  parameter int unsigned MAX_ARRAYS = 16,
  parameter int unsigned MAX_DIMS   = 16
) (
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  opcode,
  input  wire logic [3:0]  array_id,
  input  wire logic [3:0]  dim_pos,
  input  wire logic [31:0] word_a,
  input  wire logic [31:0] word_b,
  input  wire logic        last_index,
  output cmd_t             cmd,
  output logic             cmd_push,
  input  wire logic        cmd_full
);

  logic [3:0] id_lut  [16];
  logic [3:0] pos_lut [16];

  for (genvar i = 0; i < 16; i++) begin : g_lut
    assign id_lut[i]  = 4'(i % MAX_ARRAYS);
    assign pos_lut[i] = 4'(i % MAX_DIMS);
  end

  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full && (opcode != OP_NOP);

  always_comb begin
    cmd.id     = id_lut[array_id];
    cmd.pos    = pos_lut[dim_pos];
    cmd.word_a = word_a;
    cmd.word_b = word_b;
    cmd.last   = last_index;
    cmd.kind   = CMD_IDX;
    unique case (opcode)
      OP_HDR: begin
        cmd.kind = CMD_HDR;
        cmd.pos  = dim_pos;
      end
      OP_DIM: begin
        cmd.kind   = CMD_DIM;
        cmd.word_b = word_b - word_a + 32'd1;
      end
      OP_IDX:  cmd.kind = CMD_IDX;
      default: cmd.kind = CMD_IDX;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/adac_back.sv @@
`default_nettype none

module adac_back
  import adac_pkg::*;
#(
  parameter int unsigned MAX_ARRAYS = 16,
  parameter int unsigned MAX_DIMS   = 16,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  input  wire logic cmd_empty,
  output logic      cmd_pop,
  output res_t      res,
  output logic      res_push,
  input  wire logic res_full
);

  localparam int unsigned ID_W   = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
  localparam int unsigned NSLOT  = MAX_ARRAYS * MAX_DIMS;
  localparam int unsigned SLOT_W = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam logic [31:0] ADDR_MASK =
    (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_WIDTH) - 64'd1);

  logic [31:0] base_mem [MAX_ARRAYS];
  logic [31:0] size_mem [MAX_ARRAYS];
  logic [3:0]  dcnt_mem [MAX_ARRAYS];
  logic [31:0] low_mem  [NSLOT];
  logic [31:0] len_mem  [NSLOT];

  back_state_t       state;
  back_state_t       state_next;
  logic [ID_W-1:0]   id_idx;
  logic [SLOT_W-1:0] slot;
  logic              take;

  logic [31:0] base_q;
  logic [31:0] size_q;
  logic [3:0]  dcnt_q;
  logic [31:0] low_q;
  logic [31:0] len_q;
  logic [31:0] index_q;
  logic [3:0]  id_q;
  logic        last_q;
  logic [31:0] acc;
  logic [4:0]  cnt;
  logic        ok_q;

  assign id_idx  = ID_W'(cmd.id);
  assign slot    = SLOT_W'(cmd.id) * SLOT_W'(MAX_DIMS) + SLOT_W'(cmd.pos);
  assign take    = (state == ST_IDLE) && !cmd_empty;
  assign cmd_pop = take;

  always_ff @(posedge clk) begin
    if (take && (cmd.kind == CMD_HDR)) begin
      base_mem[id_idx] <= cmd.word_a;
      size_mem[id_idx] <= cmd.word_b;
      dcnt_mem[id_idx] <= cmd.pos;
    end
    if (take && (cmd.kind == CMD_IDX)) begin
      base_q <= base_mem[id_idx];
      size_q <= size_mem[id_idx];
      dcnt_q <= dcnt_mem[id_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (take && (cmd.kind == CMD_DIM)) begin
      low_mem[slot] <= cmd.word_a;
      len_mem[slot] <= cmd.word_b;
    end
    if (take && (cmd.kind == CMD_IDX)) begin
      low_q <= low_mem[slot];
      len_q <= len_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      index_q <= cmd.word_a;
      id_q    <= cmd.id;
      last_q  <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take && (cmd.kind == CMD_IDX)) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        state_next = last_q ? ST_ADDR : ST_IDLE;
      end
      ST_ADDR: begin
        if (!res_full) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign res_push     = (state == ST_ADDR) && !res_full;
  assign res.address  = (base_q + size_q * acc) & ADDR_MASK;
  assign res.id       = id_q;
  assign res.count_ok = ok_q;

  always_ff @(posedge clk) begin
    if (state == ST_ACC) begin
      ok_q <= (({1'b0, cnt} + 6'd1) == {2'b00, dcnt_q});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else if (state == ST_ACC) begin
      acc <= acc * len_q + (index_q - low_q);
      if (!last_q && (cnt != 5'd31)) begin
        cnt <= cnt + 5'd1;
      end
    end else if (res_push) begin
      acc <= '0;
      cnt <= '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/array_descriptor_address_calc_unit.sv @@
// Header and bound writes go into the tables as they leave the command queue.
// An index transaction passes through a registered table read and then the
// multiply-accumulate; the final index adds a state for base plus size times offset,
// which holds until the result queue has room for the result.
// The next command is taken from the queue only once the back end is idle again.
// Reset clears the queues, the state, the accumulator and the count; tables start undefined.
`default_nettype none

module array_descriptor_address_calc_unit
  import adac_pkg::*;
#(
  parameter int unsigned MAX_ARRAYS = 16,
  parameter int unsigned MAX_DIMS   = 16,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         opcode,
  input  wire logic [3:0]         array_id,
  input  wire logic [3:0]         dim_pos,
  input  wire logic signed [31:0] word_a,
  input  wire logic signed [31:0] word_b,
  input  wire logic               last_index,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [31:0]      address,
  output logic [3:0]              array_id_out,
  output logic                    count_ok
);

  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;
  res_t res_in;
  res_t res_head;
  logic res_push;
  logic res_full;

  adac_front #(
    .MAX_ARRAYS(MAX_ARRAYS),
    .MAX_DIMS  (MAX_DIMS)
  ) u_front (
    .push      (push),
    .full      (full),
    .opcode    (opcode),
    .array_id  (array_id),
    .dim_pos   (dim_pos),
    .word_a    (word_a),
    .word_b    (word_b),
    .last_index(last_index),
    .cmd       (cmd_in),
    .cmd_push  (cmd_push),
    .cmd_full  (cmd_full)
  );

  adac_fifo #(
    .WIDTH($bits(cmd_t))
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .wdata(cmd_in),
    .full (cmd_full),
    .pop  (cmd_pop),
    .rdata(cmd_head),
    .empty(cmd_empty)
  );

  adac_back #(
    .MAX_ARRAYS(MAX_ARRAYS),
    .MAX_DIMS  (MAX_DIMS),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_head),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .res      (res_in),
    .res_push (res_push),
    .res_full (res_full)
  );

  adac_fifo #(
    .WIDTH($bits(res_t))
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_in),
    .full (res_full),
    .pop  (pop),
    .rdata(res_head),
    .empty(empty)
  );

  assign address      = res_head.address;
  assign array_id_out = res_head.id;
  assign count_ok     = res_head.count_ok;

  // An ignored opcode is taken from the input but never reaches the command queue.
  a_nop_dropped: assert property (@(posedge clk) disable iff (rst)
    (push && !full && (opcode == OP_NOP)) |-> !cmd_push)
    else $error("ignored opcode entered the command queue");

  a_cmd_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("command taken from an empty queue");

  a_res_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result written to a full queue");

  a_res_visible: assert property (@(posedge clk) disable iff (rst)
    res_push |=> !empty)
    else $error("result transaction not visible after it was queued");

endmodule

`default_nettype wire

@@ test/array_descriptor_address_calc_unit_test.sv @@
`timescale 1ns / 1ps

module array_descriptor_address_calc_unit_test
  import adac_pkg::*;
();

  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  opcode = OP_NOP;
  logic [3:0]  array_id = '0;
  logic [3:0]  dim_pos = '0;
  logic [31:0] word_a = '0;
  logic [31:0] word_b = '0;
  logic        last_index = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] address;
  logic [3:0]  array_id_out;
  logic        count_ok;

  array_descriptor_address_calc_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .opcode       (opcode),
    .array_id     (array_id),
    .dim_pos      (dim_pos),
    .word_a       (word_a),
    .word_b       (word_b),
    .last_index   (last_index),
    .empty        (empty),
    .pop          (pop),
    .address      (address),
    .array_id_out (array_id_out),
    .count_ok     (count_ok)
  );

  always #2 clk = ~clk;

  // Expected view of the descriptor tables and the running reference.
  logic [31:0] base_mem [16];
  logic [31:0] size_mem [16];
  logic [4:0]  ndims_mem [16];
  logic [31:0] lower_mem [256];
  logic [31:0] len_mem [256];
  bit          hdr_valid [16];
  bit          dim_valid [256];
  logic [31:0] acc_r = '0;
  logic [4:0]  idx_cnt = '0;

  res_t pending_addresses [$];
  res_t head_res;
  int   errors = 0;
  int   items_sent = 0;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   hold_requests = 0;
  int   hold_seen = 0;
  int   hold_left = 0;

  function automatic bit compute_address_item(input op_t op, input logic [3:0] id,
                                              input logic [3:0] pos, input logic [31:0] a,
                                              input logic [31:0] b, input logic last,
                                              output res_t res);
    logic [7:0] slot;
    int unsigned count;
    slot = {id, pos};
    res = '0;
    compute_address_item = 1'b0;
    case (op)
      OP_HDR: begin
        base_mem[id] = a;
        size_mem[id] = b;
        ndims_mem[id] = {1'b0, pos};
        hdr_valid[id] = 1'b1;
      end
      OP_DIM: begin
        lower_mem[slot] = a;
        len_mem[slot] = b - a + 32'd1;
        dim_valid[slot] = 1'b1;
      end
      OP_IDX: begin
        acc_r = acc_r * len_mem[slot] + (a - lower_mem[slot]);
        if (!last) begin
          if (idx_cnt < 5'd31) idx_cnt = idx_cnt + 5'd1;
        end else begin
          count = 32'(idx_cnt) + 32'd1;
          res.address = base_mem[id] + size_mem[id] * acc_r;
          res.id = id;
          res.count_ok = (count == 32'(ndims_mem[id]));
          acc_r = '0;
          idx_cnt = '0;
          compute_address_item = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: rand_word = 32'h0000_0000;
      1: rand_word = 32'h7FFF_FFFF;
      2: rand_word = 32'h8000_0000;
      3: rand_word = 32'hFFFF_FFFF;
      default: rand_word = $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_index(input logic [7:0] slot);
    if (len_mem[slot] != 0 && len_mem[slot] <= 64 && $urandom_range(3) != 0)
      pick_index = lower_mem[slot] + $urandom_range(len_mem[slot] - 1);
    else
      pick_index = rand_word();
  endfunction

  task automatic send_item(input op_t op, input logic [3:0] id, input logic [3:0] pos,
                           input logic [31:0] a, input logic [31:0] b, input logic last);
    res_t res;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    opcode <= op;
    array_id <= id;
    dim_pos <= pos;
    word_a <= a;
    word_b <= b;
    last_index <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    if (compute_address_item(op, id, pos, a, b, last, res)) pending_addresses.push_back(res);
    if (op != OP_NOP) items_sent++;
  endtask

  task automatic ensure_bounds(input logic [3:0] id, input logic [3:0] pos);
    logic [31:0] lo;
    logic [31:0] hi;
    if (!dim_valid[{id, pos}] || $urandom_range(7) == 0) begin
      lo = rand_word();
      hi = ($urandom_range(9) < 7) ? lo + $urandom_range(15) : rand_word();
      send_item(OP_DIM, id, pos, lo, hi, 1'($urandom_range(1)));
    end
  endtask

  task automatic random_reference();
    logic [3:0] id;
    logic [3:0] pos;
    logic [3:0] other;
    int nd;
    int nidx;
    id = 4'($urandom_range(15));
    nd = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 4);
    if (!hdr_valid[id] || $urandom_range(4) == 0) begin
      send_item(OP_HDR, id, nd[3:0], rand_word(),
                ($urandom_range(3) == 0) ? rand_word() : (32'd1 << $urandom_range(3)),
                1'($urandom_range(1)));
    end else begin
      nd = int'(ndims_mem[id]);
    end
    nidx = ($urandom_range(4) == 0) ? $urandom_range(1, nd + 2) : nd;
    if (nidx == 0) nidx = 1;
    for (int k = 0; k < nidx; k++) begin
      other = ($urandom_range(9) == 0 && k != nidx - 1) ? 4'($urandom_range(15)) : id;
      pos = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'(k);
      ensure_bounds(other, pos);
      if ($urandom_range(11) == 0) begin
        if ($urandom_range(1) == 0)
          send_item(OP_NOP, 4'($urandom_range(15)), 4'($urandom_range(15)), $urandom,
                    $urandom, 1'($urandom_range(1)));
        else
          ensure_bounds(4'($urandom_range(15)), 4'($urandom_range(15)));
      end
      send_item(OP_IDX, other, pos, pick_index({other, pos}), $urandom, k == nidx - 1);
    end
  endtask

  task automatic wait_results_drained();
    push <= 1'b0;
    while (pending_addresses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic test_descriptor_basics();
    send_item(OP_HDR, 4'd0, 4'd2, 32'h0000_1000, 32'd4, 1'b0);
    send_item(OP_DIM, 4'd0, 4'd0, 32'd0, 32'd9, 1'b0);
    send_item(OP_DIM, 4'd0, 4'd1, -32'sd5, 32'sd5, 1'b1);
    send_item(OP_IDX, 4'd0, 4'd0, 32'd3, 32'hFFFF_FFFF, 1'b0);
    send_item(OP_IDX, 4'd0, 4'd1, 32'd2, 32'h0, 1'b1);
    send_item(OP_HDR, 4'd15, 4'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_DIM, 4'd15, 4'd15, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_item(OP_IDX, 4'd15, 4'd15, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_item(OP_NOP, 4'd15, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_NOP, 4'd0, 4'd0, 32'h0, 32'h0, 1'b0);
    // Too few indices for the declared count.
    send_item(OP_IDX, 4'd0, 4'd0, 32'd9, 32'd0, 1'b1);
    // Descriptor rewritten while a reference is in flight.
    send_item(OP_IDX, 4'd0, 4'd0, 32'd1, 32'd0, 1'b0);
    send_item(OP_HDR, 4'd0, 4'd2, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_item(OP_DIM, 4'd0, 4'd1, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_item(OP_IDX, 4'd0, 4'd1, 32'h7FFF_FFFF, 32'd0, 1'b1);
    // A declared count of zero never matches.
    send_item(OP_HDR, 4'd3, 4'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_item(OP_DIM, 4'd3, 4'd0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_item(OP_IDX, 4'd3, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    // Indices taken from other arrays and dimensions out of order.
    send_item(OP_IDX, 4'd15, 4'd15, 32'h0, 32'h0, 1'b0);
    send_item(OP_IDX, 4'd0, 4'd1, 32'hFFFF_FFFF, 32'h0, 1'b1);
  endtask

  task automatic test_index_count_saturation();
    send_item(OP_HDR, 4'd5, 4'd15, 32'h0000_4000, 32'd8, 1'b0);
    for (int k = 0; k < 15; k++) send_item(OP_DIM, 4'd5, 4'(k), -32'sd2, 32'sd1, 1'b0);
    for (int k = 0; k < 15; k++) send_item(OP_IDX, 4'd5, 4'(k), 32'd1, 32'd0, k == 14);
    for (int k = 0; k < 34; k++)
      send_item(OP_IDX, 4'd5, 4'(k % 15), -32'sd1, 32'd0, k == 33);
  endtask

  task automatic test_random_references(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) random_reference();
    wait_results_drained();
  endtask

  task automatic test_result_backpressure();
    int target;
    send_idle = 0;
    recv_idle = 0;
    hold_requests <= hold_requests + 1;
    target = items_sent + 60;
    while (items_sent < target) random_reference();
    wait_results_drained();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      hold_left <= 0;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_addresses.size() == 0) begin
        $error("unexpected transaction: address %h array_id_out %0d count_ok %0b",
               address, array_id_out, count_ok);
        errors++;
      end else begin
        head_res = pending_addresses.pop_front();
        if (address !== head_res.address) begin
          $error("address: expected %h, got %h", head_res.address, address);
          errors++;
        end
        if (array_id_out !== head_res.id) begin
          $error("array_id_out: expected %0d, got %0d", head_res.id, array_id_out);
          errors++;
        end
        if (count_ok !== head_res.count_ok) begin
          $error("count_ok: expected %0b, got %0b", head_res.count_ok, count_ok);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    send_idle = 38;
    recv_idle = 82;
    test_descriptor_basics();
    test_index_count_saturation();
    test_random_references(150);
    send_idle = 82;
    recv_idle = 38;
    test_random_references(150);
    send_idle = 0;
    recv_idle = 0;
    test_random_references(150);
    test_result_backpressure();
    if (errors == 0) begin
      $display("array_descriptor_address_calc_unit_test: clean");
    end else begin
      $display("array_descriptor_address_calc_unit_test: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("array_descriptor_address_calc_unit_test: errors");
    $finish;
  end

endmodule
